FILE: hw/rtl/spp_pkg.sv
package spp_pkg;

  localparam int FFT_SIZE     = 4096;
  localparam int MAX_PEAKS    = 16;
  localparam int REPORT_PEAKS = 8;

  localparam int IN_W   = 24;
  localparam int SQ_W   = 2 * IN_W - 1;
  localparam int POW_W  = 48;
  localparam int BIN_W  = 11;
  localparam int CFG_W  = 48;
  localparam int CFGI_W = 2;

  // bin counter saturates at FFT_SIZE/2+1
  localparam int CNT_W   = $clog2(FFT_SIZE / 2 + 2);
  localparam int IDX_W   = (CNT_W > BIN_W) ? CNT_W : BIN_W;
  localparam int PCNT_W  = $clog2(MAX_PEAKS + 1);
  localparam int ELEFT_W = $clog2(REPORT_PEAKS + 1);

  localparam logic [CFGI_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_LOW_BIN   = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_HIGH_BIN  = 2'd2;

  localparam logic [POW_W-1:0] RST_THRESHOLD = 48'd400;
  localparam logic [BIN_W-1:0] RST_LOW_BIN   = 11'd7;
  localparam logic [BIN_W-1:0] RST_HIGH_BIN  = 11'd140;

  typedef struct packed {
    logic signed [IN_W-1:0] bin_re;
    logic signed [IN_W-1:0] bin_im;
    logic                   frame_end;
  } spp_in_t;

  typedef struct packed {
    logic             found;
    logic [BIN_W-1:0] peak_bin;
    logic [POW_W-1:0] peak_power;
    logic             last_peak;
  } spp_out_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [POW_W-1:0] power;
  } spp_entry_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } spp_cell_ctrl_t;

endpackage

FILE: hw/rtl/spp_power.sv
module spp_power (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  spp_pkg::spp_in_t              in_request,
  output logic                          sq_valid,
  output logic                          sq_frame_end,
  output logic [spp_pkg::SQ_W-1:0]      re_sq,
  output logic [spp_pkg::SQ_W-1:0]      im_sq
);
  import spp_pkg::*;

  logic [IN_W-1:0]   re_abs;
  logic [IN_W-1:0]   im_abs;
  logic [SQ_W-1:0]   re_prod;
  logic [SQ_W-1:0]   im_prod;
  logic              sq_valid_r;
  logic              sq_frame_end_r;
  logic [SQ_W-1:0]   re_sq_r;
  logic [SQ_W-1:0]   im_sq_r;

  // most negative value maps to 2^23, which still fits unsigned
  assign re_abs = in_request.bin_re[IN_W-1] ? (~in_request.bin_re + 1'b1) : in_request.bin_re;
  assign im_abs = in_request.bin_im[IN_W-1] ? (~in_request.bin_im + 1'b1) : in_request.bin_im;
  assign re_prod = re_abs * re_abs;
  assign im_prod = im_abs * im_abs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
    end else begin
      sq_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sq_frame_end_r <= in_request.frame_end;
      re_sq_r        <= re_prod;
      im_sq_r        <= im_prod;
    end
  end

  assign sq_valid     = sq_valid_r;
  assign sq_frame_end = sq_frame_end_r;
  assign re_sq        = re_sq_r;
  assign im_sq        = im_sq_r;

endmodule

FILE: hw/rtl/spp_cell.sv
module spp_cell (
  input  logic                    clk,
  input  spp_pkg::spp_cell_ctrl_t ctrl,
  input  logic                    occupied,
  input  spp_pkg::spp_entry_t     new_entry,
  input  spp_pkg::spp_entry_t     left_entry,
  input  logic                    left_ge,
  input  spp_pkg::spp_entry_t     right_entry,
  output spp_pkg::spp_entry_t     entry,
  output logic                    ge
);
  import spp_pkg::*;

  spp_entry_t entry_r;
  spp_entry_t entry_nxt;

  // equal power stays ahead, so later arrivals land behind it
  assign ge = occupied && (entry_r.power >= new_entry.power);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.shift) begin
      entry_nxt = right_entry;
    end else if (ctrl.insert && !ge) begin
      entry_nxt = left_ge ? new_entry : left_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

FILE: hw/rtl/spectral_peak_picker.sv
// Spectral peak picker. Takes one frame of FFT bins, bin 0 first, one request per
// cycle while busy is low. The last bin of a frame is the request with frame_end set;
// after it busy stays high through the report phase; N is the number of results
// (the strongest peaks, at most 8, or one empty result when no peak was found).
// Results come out one per cycle on out_strobe, strongest first, after the frame_end
// request has passed the squaring register, the report state and the output register;
// last_peak marks the final one. Results cannot be held off, so they must be taken the
// cycle they appear. The peak list is a row of 16 compare-shift cells that sorts each
// new peak in place and shifts out toward cell 0 during reporting, setting the N-result
// report phase. Configuration must be written only while no frame is in progress.
module spectral_peak_picker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  spp_pkg::spp_in_t            in_request,
  output logic                        out_strobe,
  output spp_pkg::spp_out_t           out_result,
  input  logic                        cfg_we,
  input  logic [spp_pkg::CFGI_W-1:0]  cfg_index,
  input  logic [spp_pkg::CFG_W-1:0]   cfg_data
);
  import spp_pkg::*;

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic              take;
  logic              sq_valid;
  logic              sq_frame_end;
  logic [SQ_W-1:0]   re_sq;
  logic [SQ_W-1:0]   im_sq;
  logic [POW_W-1:0]  power;

  logic [POW_W-1:0]  thr_r;
  logic [BIN_W-1:0]  low_r;
  logic [BIN_W-1:0]  high_r;

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  bin_cnt_r, bin_cnt_nxt;
  logic [POW_W-1:0]  prev_r, prev_nxt;
  logic [POW_W-1:0]  cand_r, cand_nxt;
  logic [PCNT_W-1:0] peak_count_r, peak_count_nxt;
  logic [ELEFT_W-1:0] emit_left_r, emit_left_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  spp_out_t          out_result_r, out_result_nxt;

  logic [CNT_W-1:0]  cand_idx;
  logic              is_peak;
  logic              insert;
  logic [PCNT_W-1:0] count_after;
  spp_entry_t        new_entry;
  spp_cell_ctrl_t    cell_ctrl;

  spp_entry_t        cells [MAX_PEAKS];
  logic [MAX_PEAKS-1:0] cell_ge;
  logic [MAX_PEAKS-1:0] cell_occ;

  assign busy = (state_r == ST_EMIT) || (sq_valid && sq_frame_end);
  assign take = start && !busy;

  spp_power u_power (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .in_request   (in_request),
    .sq_valid     (sq_valid),
    .sq_frame_end (sq_frame_end),
    .re_sq        (re_sq),
    .im_sq        (im_sq)
  );

  assign power = POW_W'(re_sq) + POW_W'(im_sq);

  // candidate is the bin one back, judged with the current bin as right neighbor
  assign cand_idx = bin_cnt_r - 1'b1;
  assign is_peak  = sq_valid
                 && (bin_cnt_r >= CNT_W'(2))
                 && (cand_idx <= CNT_W'(FFT_SIZE / 2 - 1))
                 && (cand_r > thr_r)
                 && (cand_r >= prev_r)
                 && (cand_r >= power)
                 && (IDX_W'(cand_idx) >= IDX_W'(low_r))
                 && (IDX_W'(cand_idx) <= IDX_W'(high_r));
  assign insert = is_peak && (peak_count_r < PCNT_W'(MAX_PEAKS));

  assign new_entry.bin   = BIN_W'(cand_idx);
  assign new_entry.power = cand_r;
  assign count_after     = peak_count_r + PCNT_W'(insert);

  assign cell_ctrl.insert = insert;
  assign cell_ctrl.shift  = (state_r == ST_EMIT);

  for (genvar i = 0; i < MAX_PEAKS; i++) begin : g_cell
    spp_entry_t left_e;
    spp_entry_t right_e;
    logic       left_g;

    assign cell_occ[i] = PCNT_W'(i) < peak_count_r;

    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign left_g = 1'b1;
    end else begin : g_body
      assign left_e = cells[i-1];
      assign left_g = cell_ge[i-1];
    end

    if (i == MAX_PEAKS - 1) begin : g_tail
      assign right_e = new_entry;
    end else begin : g_mid
      assign right_e = cells[i+1];
    end

    spp_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl),
      .occupied    (cell_occ[i]),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_ge     (left_g),
      .right_entry (right_e),
      .entry       (cells[i]),
      .ge          (cell_ge[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    bin_cnt_nxt    = bin_cnt_r;
    prev_nxt       = prev_r;
    cand_nxt       = cand_r;
    peak_count_nxt = peak_count_r;
    emit_left_nxt  = emit_left_r;
    out_strobe_nxt = 1'b0;

    out_result_nxt.found      = (peak_count_r != '0);
    out_result_nxt.peak_bin   = (peak_count_r != '0) ? cells[0].bin : '0;
    out_result_nxt.peak_power = (peak_count_r != '0) ? cells[0].power : '0;
    out_result_nxt.last_peak  = (emit_left_r == ELEFT_W'(1));

    if (state_r == ST_EMIT) begin
      out_strobe_nxt = 1'b1;
      emit_left_nxt  = emit_left_r - 1'b1;
      if (emit_left_r == ELEFT_W'(1)) begin
        state_nxt      = ST_RUN;
        peak_count_nxt = '0;
      end
    end else if (sq_valid) begin
      peak_count_nxt = count_after;
      if (!sq_frame_end) begin
        prev_nxt = cand_r;
        cand_nxt = power;
        if (bin_cnt_r < CNT_W'(FFT_SIZE / 2 + 1)) begin
          bin_cnt_nxt = bin_cnt_r + 1'b1;
        end
      end else begin
        prev_nxt    = '0;
        cand_nxt    = '0;
        bin_cnt_nxt = '0;
        state_nxt   = ST_EMIT;
        if (count_after == '0) begin
          emit_left_nxt = ELEFT_W'(1);
        end else if (int'(count_after) >= REPORT_PEAKS) begin
          emit_left_nxt = ELEFT_W'(REPORT_PEAKS);
        end else begin
          emit_left_nxt = ELEFT_W'(count_after);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= RST_THRESHOLD;
      low_r        <= RST_LOW_BIN;
      high_r       <= RST_HIGH_BIN;
      state_r      <= ST_RUN;
      bin_cnt_r    <= '0;
      prev_r       <= '0;
      cand_r       <= '0;
      peak_count_r <= '0;
      emit_left_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bin_cnt_r    <= bin_cnt_nxt;
      prev_r       <= prev_nxt;
      cand_r       <= cand_nxt;
      peak_count_r <= peak_count_nxt;
      emit_left_r  <= emit_left_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THRESHOLD: thr_r  <= cfg_data[POW_W-1:0];
          CFG_LOW_BIN:   low_r  <= cfg_data[BIN_W-1:0];
          CFG_HIGH_BIN:  high_r <= cfg_data[BIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    peak_count_r <= PCNT_W'(MAX_PEAKS))
    else $error("peak count exceeds list depth");

  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_result_r.last_peak |=> out_strobe_r)
    else $error("result burst broken before last_peak");

  a_burst_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_result_r.last_peak |=>
      out_result_r.peak_power <= $past(out_result_r.peak_power))
    else $error("results not in descending power order");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_result_r.found |-> out_result_r.last_peak)
    else $error("empty result not marked last");

  a_no_take_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> busy && !sq_valid)
    else $error("request taken during report phase");
`endif

endmodule

FILE: verif/tb_spectral_peak_picker.sv
`timescale 1ns / 1ps

module tb_spectral_peak_picker;
  import spp_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int FLUSH_CYCLES = 4;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_BINS  = 300;

  class peak_ranker_model;
    logic [POW_W-1:0] threshold;
    logic [BIN_W-1:0] band_lo;
    logic [BIN_W-1:0] band_hi;
    int unsigned      bin_pos;
    logic [POW_W-1:0] power_two_back;
    logic [POW_W-1:0] power_one_back;
    spp_entry_t       ranked[MAX_PEAKS];
    int unsigned      ranked_count;
    spp_out_t         expected_peaks[$];
    int               mismatches;

    function new();
      threshold  = RST_THRESHOLD;
      band_lo    = RST_LOW_BIN;
      band_hi    = RST_HIGH_BIN;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      bin_pos        = 0;
      power_two_back = '0;
      power_one_back = '0;
      ranked_count   = 0;
    endfunction

    function int pending();
      return expected_peaks.size();
    endfunction

    function void write_reg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_THRESHOLD: threshold = data[POW_W-1:0];
        CFG_LOW_BIN:   band_lo = data[BIN_W-1:0];
        CFG_HIGH_BIN:  band_hi = data[BIN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [POW_W-1:0] bin_power(spp_in_t req);
      logic [IN_W-1:0]  mag_re;
      logic [IN_W-1:0]  mag_im;
      logic [POW_W-1:0] wide_re;
      logic [POW_W-1:0] wide_im;
      mag_re = req.bin_re;
      mag_im = req.bin_im;
      if (mag_re[IN_W-1]) mag_re = ~mag_re + 1'b1;
      if (mag_im[IN_W-1]) mag_im = ~mag_im + 1'b1;
      wide_re = mag_re;
      wide_im = mag_im;
      return wide_re * wide_re + wide_im * wide_im;
    endfunction

    // equal powers go behind the ones already held
    function void rank_peak(int unsigned b, logic [POW_W-1:0] p);
      int unsigned slot;
      if (ranked_count >= MAX_PEAKS) return;
      slot = 0;
      while (slot < ranked_count && ranked[slot].power >= p) slot++;
      for (int unsigned i = ranked_count; i > slot; i--) ranked[i] = ranked[i-1];
      ranked[slot].bin   = BIN_W'(b);
      ranked[slot].power = p;
      ranked_count++;
    endfunction

    function void judge_candidate(logic [POW_W-1:0] right);
      int unsigned cand;
      if (bin_pos < 2) return;
      cand = bin_pos - 1;
      if (cand > FFT_SIZE / 2 - 1) return;
      if (power_one_back > threshold && power_one_back >= power_two_back &&
          power_one_back >= right && cand >= band_lo && cand <= band_hi) begin
        rank_peak(cand, power_one_back);
      end
    endfunction

    function void take_bin(spp_in_t req);
      logic [POW_W-1:0] p;
      spp_out_t         res;
      int unsigned      shown;
      p = bin_power(req);
      judge_candidate(p);
      if (!req.frame_end) begin
        power_two_back = power_one_back;
        power_one_back = p;
        if (bin_pos < FFT_SIZE / 2 + 1) bin_pos++;
        return;
      end
      if (ranked_count == 0) begin
        res = '0;
        res.last_peak = 1'b1;
        expected_peaks.push_back(res);
      end else begin
        shown = (ranked_count < REPORT_PEAKS) ? ranked_count : REPORT_PEAKS;
        for (int unsigned i = 0; i < shown; i++) begin
          res.found      = 1'b1;
          res.peak_bin   = ranked[i].bin;
          res.peak_power = ranked[i].power;
          res.last_peak  = (i == shown - 1);
          expected_peaks.push_back(res);
        end
      end
      clear_frame();
    endfunction

    task report_mismatch(string field, logic [63:0] got_v, logic [63:0] want_v);
      mismatches++;
      if (mismatches <= 100)
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, field, got_v, want_v);
    endtask

    task check_peak(spp_out_t got);
      spp_out_t want;
      if (expected_peaks.size() == 0) begin
        report_mismatch("result with nothing pending, peak_bin", got.peak_bin, 0);
        return;
      end
      want = expected_peaks.pop_front();
      if (got.found !== want.found) report_mismatch("found", got.found, want.found);
      if (got.peak_bin !== want.peak_bin)
        report_mismatch("peak_bin", got.peak_bin, want.peak_bin);
      if (got.peak_power !== want.peak_power)
        report_mismatch("peak_power", got.peak_power, want.peak_power);
      if (got.last_peak !== want.last_peak)
        report_mismatch("last_peak", got.last_peak, want.last_peak);
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  spp_in_t            in_request = '0;
  logic               out_strobe;
  spp_out_t           out_result;
  logic               cfg_we = 1'b0;
  logic [CFGI_W-1:0]  cfg_index = CFG_THRESHOLD;
  logic [CFG_W-1:0]   cfg_data = '0;

  bit                 steady_sender = 1'b0;
  int                 quiet_cycles = 0;
  spp_in_t            frame_bins[$];
  peak_ranker_model   ranker = new();

  spectral_peak_picker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_request (in_request),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sample at the edge, before any driver update of this step lands
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_we) ranker.write_reg(cfg_index, cfg_data);
      if (start && !busy) begin
        ranker.take_bin(in_request);
        quiet_cycles = 0;
      end
      if (out_strobe) begin
        ranker.check_peak(out_result);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic signed [IN_W-1:0] signed_part(int unsigned mag);
    logic signed [IN_W-1:0] v;
    if (mag >= 32'd8388608) return {1'b1, {(IN_W-1){1'b0}}};
    v = mag[IN_W-1:0];
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic signed [IN_W-1:0] rand24();
    logic [31:0] r;
    r = $urandom;
    return r[IN_W-1:0];
  endfunction

  function automatic void add_bin(logic signed [IN_W-1:0] re, logic signed [IN_W-1:0] im);
    spp_in_t req;
    req.bin_re    = re;
    req.bin_im    = im;
    req.frame_end = 1'b0;
    frame_bins.push_back(req);
  endfunction

  function automatic int unsigned peak_mag();
    int unsigned sel;
    sel = $urandom_range(0, 3);
    case (sel)
      // a few fixed levels so equal powers show up
      0: begin
        sel = $urandom_range(0, 2);
        return (sel == 0) ? 40 : (sel == 1) ? 300 : 2000;
      end
      1: return $urandom_range(21, 65535);
      2: return $urandom_range(0, 8388608);
      default: return $urandom_range(21, 200);
    endcase
  endfunction

  function automatic void add_peak(int unsigned mag);
    case ($urandom_range(0, 2))
      0: add_bin(signed_part(mag), '0);
      1: add_bin('0, signed_part(mag));
      default: add_bin(signed_part(mag), signed_part(peak_mag()));
    endcase
  endfunction

  function automatic void build_peaky(int len, bit dense);
    for (int b = 0; b < len; b++) begin
      if (dense ? (b % 2 == 1) : ($urandom_range(0, 3) == 0))
        add_peak(peak_mag());
      else
        add_bin(signed_part($urandom_range(0, 20)), signed_part($urandom_range(0, 20)));
    end
  endfunction

  task automatic send_bin(spp_in_t req);
    in_request <= req;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic sender_pause();
    int roll;
    if (steady_sender) return;
    roll = $urandom_range(0, 99);
    if (roll < 65) return;
    start <= 1'b0;
    if (roll < 95) repeat ($urandom_range(1, 3)) @(posedge clk);
    else repeat ($urandom_range(15, 60)) @(posedge clk);
  endtask

  task automatic send_frame();
    frame_bins[frame_bins.size()-1].frame_end = 1'b1;
    foreach (frame_bins[i]) begin
      send_bin(frame_bins[i]);
      if (i != frame_bins.size() - 1) sender_pause();
    end
    frame_bins.delete();
  endtask

  // hold requests until the frame report is out and the block is idle
  task automatic wait_frame_flushed();
    start <= 1'b0;
    @(posedge clk);
    while (ranker.pending() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_regs(logic [POW_W-1:0] thr, logic [BIN_W-1:0] lo,
                            logic [BIN_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= CFG_LOW_BIN;
    cfg_data  <= CFG_W'(lo);
    @(posedge clk);
    cfg_index <= CFG_HIGH_BIN;
    cfg_data  <= CFG_W'(hi);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_random_regs();
    logic [POW_W-1:0] thr;
    logic [BIN_W-1:0] lo;
    logic [BIN_W-1:0] hi;
    logic [63:0]      wide;
    case ($urandom_range(0, 5))
      0: thr = '0;
      1: thr = 48'h8000_0000_0000;
      2: begin
        wide = {$urandom, $urandom};
        thr  = wide[POW_W-1:0];
      end
      3: thr = POW_W'($urandom_range(0, 1000));
      4: thr = POW_W'($urandom_range(0, 1 << 20));
      default: thr = RST_THRESHOLD;
    endcase
    case ($urandom_range(0, 4))
      0: lo = 11'd1;
      1: lo = 11'd2047;
      2: lo = BIN_W'($urandom_range(1, 2047));
      default: lo = BIN_W'($urandom_range(1, 30));
    endcase
    case ($urandom_range(0, 4))
      0: hi = 11'd2047;
      1: hi = BIN_W'($urandom_range(1, 2047));
      2: hi = (lo > 1) ? lo - 1'b1 : lo;
      default: hi = (lo > 11'd1967) ? 11'd2047 : BIN_W'(lo + $urandom_range(0, 80));
    endcase
    write_regs(thr, lo, hi);
  endtask

  initial begin
    int random_bins;
    int style;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait_frame_flushed();

    // frame of a single request, then one that ends on bin 1: both empty
    add_bin(24'sh7fffff, 24'sh7fffff);
    send_frame();
    add_bin(24'sh800000, 24'sh7fffff);
    add_bin('0, '0);
    send_frame();

    // reset band: bin 5 lies below it, bin 8 is judged against the frame end
    for (int b = 0; b < 10; b++) begin
      case (b)
        5: add_bin(24'sd100, '0);
        8: add_bin(24'sd20, 24'sd20);
        9: add_bin(24'sd3, '0);
        default: add_bin(24'sd1, '0);
      endcase
    end
    send_frame();
    wait_frame_flushed();

    // widest band, zero threshold, full-scale bin
    write_regs('0, 11'd1, 11'd2047);
    add_bin('0, '0);
    add_bin(24'sh800000, 24'sh800000);
    add_bin('0, '0);
    add_bin(24'sd5, -24'sd5);
    add_bin('0, '0);
    send_frame();
    wait_frame_flushed();

    // full-scale power does not strictly exceed the top threshold
    write_regs(48'h8000_0000_0000, 11'd1, 11'd2047);
    add_bin('0, '0);
    add_bin(24'sh800000, 24'sh800000);
    add_bin('0, '0);
    send_frame();
    wait_frame_flushed();

    // inverted band rejects everything
    write_regs(48'd10, 11'd6, 11'd3);
    add_bin('0, '0);
    add_bin('0, '0);
    add_bin('0, '0);
    add_bin(24'sd9, 24'sd9);
    add_bin('0, '0);
    send_frame();
    wait_frame_flushed();

    // more peaks than the list holds
    write_regs(48'd50, 11'd1, 11'd2047);
    build_peaky(60, 1'b1);
    send_frame();
    wait_frame_flushed();

    random_bins = 0;
    while (random_bins < RANDOM_BINS) begin
      if (random_bins == 0 || $urandom_range(0, 2) == 0) begin
        wait_frame_flushed();
        write_random_regs();
      end
      steady_sender = ($urandom_range(0, 3) == 0);
      style = $urandom_range(0, 9);
      case (style)
        5: build_peaky($urandom_range(20, 60), 1'b1);
        6: repeat ($urandom_range(1, 40)) add_bin(rand24(), rand24());
        7: build_peaky($urandom_range(1, 3), 1'b0);
        8: repeat ($urandom_range(2, 50))
             add_bin(signed_part(peak_mag()), signed_part(peak_mag()));
        9: build_peaky($urandom_range(100, 200), 1'b0);
        default: build_peaky($urandom_range(2, 70), 1'b0);
      endcase
      random_bins += frame_bins.size();
      send_frame();
      if ($urandom_range(0, 1)) wait_frame_flushed();
    end

    wait_frame_flushed();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ranker.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
